// File: rtl/mcl_pkg.sv
`default_nettype none

package mcl_pkg;

   localparam int WHEELS = 4;

   // datapath widths
   localparam int MAG_W   = 29;  // |wheel numerator|
   localparam int SUM_W   = 31;  // sum of four magnitudes
   localparam int PROD_W  = 45;  // magnitude times inverse radius
   localparam int Y_W     = 30;  // product after the power-of-two part of the divisor
   localparam int TQ_W    = 17;  // target quotient before saturation
   localparam int SHARE_W = 43;  // magnitude times power
   localparam int DEN1_W  = 41;  // sum times current denominator
   localparam int NUM_W   = 67;  // share times current constant
   localparam int DEN_W   = 57;  // full current denominator
   localparam int MXD_W   = 72;  // max_output times denominator
   localparam int QUO_W   = 15;  // current limit quotient

   // target = |n| * R / 512000000 = ((|n| * R) >> 15) / 15625
   localparam int              TGT_PRE_SHIFT = 15;
   localparam int              TGT_RECIP_SH  = 44;
   localparam logic [30:0]     TGT_RECIP     = 31'd1125899906;  // floor(2^44 / 15625)
   localparam logic [13:0]     TGT_ODD       = 14'd15625;
   localparam logic signed [11:0] VEL_SCALE  = 12'sd2000;
   localparam logic [WHEELS-1:0]  TGT_FLIP   = 4'b0110;         // wheels 1 and 2

   // current limit constants
   localparam logic [23:0]       CUR_MUL    = 24'd14632128;
   localparam logic [9:0]        CUR_DEN    = 10'd935;
   localparam logic [DEN1_W-1:0] CUR_DEN_ZS = 41'd1870;           // 2 * 935, equal split

   // register map
   localparam int               CSR_IDX_W      = 3;
   localparam int               CSR_DATA_W     = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_RADIUS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_POWER      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_OUT    = 3'd4;

   typedef struct packed {
      logic [11:0] width_mm;
      logic [11:0] length_mm;
      logic [15:0] inv_radius;
      logic [13:0] power;
      logic [14:0] max_out;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      width_mm:   12'd400,
      length_mm:  12'd400,
      inv_radius: 16'd3369,
      power:      14'd1280,
      max_out:    15'd16384
   };

   typedef struct packed {
      logic signed [15:0]        vel_x;
      logic signed [15:0]        vel_y;
      logic signed [15:0]        yaw_rate;
      logic [WHEELS-1:0][15:0]   rpm;
   } cmd_type;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
      logic [MXD_W-1:0] mxd;
      logic             a_zero;
      logic             ar_zero;
   } lane_type;

   typedef struct packed {
      logic [WHEELS-1:0][15:0] target;
      lane_type [WHEELS-1:0]   lane;
   } kin_out_type;

   typedef struct packed {
      logic [WHEELS-1:0][15:0] target;
      logic [WHEELS-1:0][14:0] limit;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/mcl_req_if.sv
`default_nettype none

interface mcl_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] vel_x;
   logic signed [15:0] vel_y;
   logic signed [15:0] yaw_rate;
   logic signed [15:0] rpm_0;
   logic signed [15:0] rpm_1;
   logic signed [15:0] rpm_2;
   logic signed [15:0] rpm_3;

   modport source (output valid, vel_x, vel_y, yaw_rate, rpm_0, rpm_1, rpm_2, rpm_3,
                   input ready);
   modport sink (input valid, vel_x, vel_y, yaw_rate, rpm_0, rpm_1, rpm_2, rpm_3,
                 output ready);
endinterface

`default_nettype wire

// File: rtl/mcl_rsp_if.sv
`default_nettype none

interface mcl_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] target_0;
   logic signed [15:0] target_1;
   logic signed [15:0] target_2;
   logic signed [15:0] target_3;
   logic [14:0]        limit_0;
   logic [14:0]        limit_1;
   logic [14:0]        limit_2;
   logic [14:0]        limit_3;

   modport source (output valid, target_0, target_1, target_2, target_3,
                   limit_0, limit_1, limit_2, limit_3, input ready);
   modport sink (input valid, target_0, target_1, target_2, target_3,
                 limit_0, limit_1, limit_2, limit_3, output ready);
endinterface

`default_nettype wire

// File: rtl/mcl_kin.sv
`default_nettype none

// Six-stage kinematics front end: wheel numerators, speed targets and
// the operands of the current limit division.
module mcl_kin (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  mcl_pkg::cmd_type     cmd,
   input  mcl_pkg::cfg_type     cfg,
   output logic                 out_valid,
   output mcl_pkg::kin_out_type kout
);
   import mcl_pkg::*;

   localparam int STAGES = 6;

   logic [STAGES-1:0] vld_ff;

   // stage 1 signals
   logic signed [16:0] sxy_in, dxy_in;
   logic signed [28:0] a_prod, b_prod;
   logic [12:0]        span_in;
   logic signed [29:0] rot_prod;
   logic [15:0]        ar_in [WHEELS];
   logic signed [27:0] s1_a_ff, s1_b_ff;
   logic signed [28:0] s1_rot_ff;
   logic [15:0]        s1_ar_ff [WHEELS];

   // stage 2 signals
   logic signed [29:0] a30, b30, rot30;
   logic signed [29:0] n_in [WHEELS];
   logic signed [29:0] n_abs [WHEELS];
   logic [MAG_W-1:0]   s2_mag_ff [WHEELS];
   logic [WHEELS-1:0]  s2_negt_ff;
   logic [WHEELS-1:0]  negt_in;
   logic [15:0]        s2_ar_ff [WHEELS];

   // stage 3 signals
   logic [PROD_W-1:0]  s3_p_ff [WHEELS];
   logic [SUM_W-1:0]   sum_in, s3_sum_ff;
   logic [MAG_W-1:0]   s3_mag_ff [WHEELS];
   logic [WHEELS-1:0]  s3_negt_ff;
   logic [15:0]        s3_ar_ff [WHEELS];

   // stage 4 signals
   logic [60:0]        tprod [WHEELS];
   logic               zero_sum;
   logic [Y_W-1:0]     s4_y_ff [WHEELS];
   logic [TQ_W-1:0]    s4_q0_ff [WHEELS];
   logic [SHARE_W-1:0] s4_a_ff [WHEELS];
   logic [DEN1_W-1:0]  s4_d1_ff;
   logic [15:0]        s4_ar_ff [WHEELS];
   logic [WHEELS-1:0]  s4_negt_ff;

   // stage 5 signals
   logic [Y_W-1:0]     s5_y_ff [WHEELS];
   logic [TQ_W-1:0]    s5_q0_ff [WHEELS];
   logic [30:0]        s5_qm_ff [WHEELS];
   logic [NUM_W-1:0]   s5_num_ff [WHEELS];
   logic [DEN_W-1:0]   s5_den_ff [WHEELS];
   logic [WHEELS-1:0]  s5_az_ff, s5_rz_ff, s5_negt_ff;

   // stage 6 signals
   logic [Y_W-1:0]     rem6 [WHEELS];
   logic [TQ_W-1:0]    qc6 [WHEELS];
   logic [14:0]        mag6 [WHEELS];
   logic [15:0]        t16 [WHEELS];
   kin_out_type        kout_in, kout_ff;

   // valid bits move with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[STAGES-2:0], in_valid};
      end
   end

   // stage 1: scaled linear terms, rotation term, rpm magnitudes
   always_comb begin
      sxy_in   = 17'($signed(cmd.vel_x)) + 17'($signed(cmd.vel_y));
      dxy_in   = 17'($signed(cmd.vel_y)) - 17'($signed(cmd.vel_x));
      a_prod   = sxy_in * VEL_SCALE;
      b_prod   = dxy_in * VEL_SCALE;
      span_in  = 13'(cfg.width_mm) + 13'(cfg.length_mm);
      rot_prod = $signed(cmd.yaw_rate) * $signed({1'b0, span_in});
      for (int w = 0; w < WHEELS; w++) begin
         ar_in[w] = cmd.rpm[w][15] ? 16'(~cmd.rpm[w] + 16'd1) : cmd.rpm[w];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_a_ff   <= a_prod[27:0];
         s1_b_ff   <= b_prod[27:0];
         s1_rot_ff <= rot_prod[28:0];
         for (int w = 0; w < WHEELS; w++) begin
            s1_ar_ff[w] <= ar_in[w];
         end
      end
   end

   // stage 2: wheel numerators, magnitude and target sign
   always_comb begin
      a30   = 30'(s1_a_ff);
      b30   = 30'(s1_b_ff);
      rot30 = 30'(s1_rot_ff);
      n_in[0] = a30 + rot30;
      n_in[1] = b30 - rot30;
      n_in[2] = a30 - rot30;
      n_in[3] = b30 + rot30;
      for (int w = 0; w < WHEELS; w++) begin
         n_abs[w]   = n_in[w][29] ? -n_in[w] : n_in[w];
         negt_in[w] = n_in[w][29] ^ TGT_FLIP[w];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_negt_ff <= negt_in;
         for (int w = 0; w < WHEELS; w++) begin
            s2_mag_ff[w] <= n_abs[w][MAG_W-1:0];
            s2_ar_ff[w]  <= s1_ar_ff[w];
         end
      end
   end

   // stage 3: magnitude times inverse radius, sum of magnitudes
   always_comb begin
      sum_in = '0;
      for (int w = 0; w < WHEELS; w++) begin
         sum_in = sum_in + SUM_W'(s2_mag_ff[w]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_sum_ff  <= sum_in;
         s3_negt_ff <= s2_negt_ff;
         for (int w = 0; w < WHEELS; w++) begin
            s3_p_ff[w]   <= PROD_W'(s2_mag_ff[w]) * PROD_W'(cfg.inv_radius);
            s3_mag_ff[w] <= s2_mag_ff[w];
            s3_ar_ff[w]  <= s2_ar_ff[w];
         end
      end
   end

   // stage 4: reciprocal estimate of the target, power shares, sum times current denominator
   always_comb begin
      zero_sum = (s3_sum_ff == '0) || (cfg.inv_radius == '0);
      for (int w = 0; w < WHEELS; w++) begin
         tprod[w] = 61'(s3_p_ff[w][PROD_W-1:TGT_PRE_SHIFT]) * 61'(TGT_RECIP);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_d1_ff   <= zero_sum ? CUR_DEN_ZS : DEN1_W'(s3_sum_ff) * DEN1_W'(CUR_DEN);
         s4_negt_ff <= s3_negt_ff;
         for (int w = 0; w < WHEELS; w++) begin
            s4_y_ff[w]  <= s3_p_ff[w][PROD_W-1:TGT_PRE_SHIFT];
            s4_q0_ff[w] <= tprod[w][TGT_RECIP_SH+TQ_W-1:TGT_RECIP_SH];
            s4_a_ff[w]  <= zero_sum ? SHARE_W'(cfg.power)
                                    : SHARE_W'(s3_mag_ff[w]) * SHARE_W'(cfg.power);
            s4_ar_ff[w] <= s3_ar_ff[w];
         end
      end
   end

   // stage 5: quotient check product, division operands
   always_ff @(posedge clock) begin
      if (advance) begin
         s5_negt_ff <= s4_negt_ff;
         for (int w = 0; w < WHEELS; w++) begin
            s5_y_ff[w]   <= s4_y_ff[w];
            s5_q0_ff[w]  <= s4_q0_ff[w];
            s5_qm_ff[w]  <= 31'(s4_q0_ff[w]) * 31'(TGT_ODD);
            s5_num_ff[w] <= NUM_W'(s4_a_ff[w]) * NUM_W'(CUR_MUL);
            s5_den_ff[w] <= DEN_W'(s4_d1_ff) * DEN_W'(s4_ar_ff[w]);
            s5_az_ff[w]  <= (s4_a_ff[w] == '0);
            s5_rz_ff[w]  <= (s4_ar_ff[w] == '0);
         end
      end
   end

   // stage 6: correct the quotient, saturate, apply sign; saturation product
   always_comb begin
      kout_in = kout_ff;
      for (int w = 0; w < WHEELS; w++) begin
         rem6[w] = s5_y_ff[w] - s5_qm_ff[w][Y_W-1:0];
         qc6[w]  = (rem6[w] >= Y_W'(TGT_ODD)) ? s5_q0_ff[w] + 1'b1 : s5_q0_ff[w];
         mag6[w] = (qc6[w] > TQ_W'(cfg.max_out)) ? cfg.max_out : qc6[w][14:0];
         t16[w]  = {1'b0, mag6[w]};
         kout_in.target[w]       = s5_negt_ff[w] ? -t16[w] : t16[w];
         kout_in.lane[w].num     = s5_num_ff[w];
         kout_in.lane[w].den     = s5_den_ff[w];
         kout_in.lane[w].mxd     = MXD_W'(cfg.max_out) * MXD_W'(s5_den_ff[w]);
         kout_in.lane[w].a_zero  = s5_az_ff[w];
         kout_in.lane[w].ar_zero = s5_rz_ff[w];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         kout_ff <= kout_in;
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign kout      = kout_ff;

endmodule

`default_nettype wire

// File: rtl/mcl_cur_div.sv
`default_nettype none

// Current limit divider: saturation compare, one quotient bit per stage,
// then selection of the special cases. Targets ride alongside.
module mcl_cur_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  mcl_pkg::kin_out_type kin,
   input  logic [14:0]          max_out,
   output logic                 out_valid,
   output mcl_pkg::rsp_type     rsp
);
   import mcl_pkg::*;

   localparam int STAGES = QUO_W + 2;

   logic [STAGES-1:0]       vld_ff;
   logic [NUM_W-1:0]        rem_ff [QUO_W][WHEELS];
   logic [DEN_W-1:0]        den_ff [QUO_W][WHEELS];
   logic [QUO_W-1:0]        quo_ff [QUO_W+1][WHEELS];
   logic [WHEELS-1:0]       sat_ff [QUO_W+1];
   logic [WHEELS-1:0]       az_ff  [QUO_W+1];
   logic [WHEELS-1:0]       rz_ff  [QUO_W+1];
   logic [WHEELS-1:0][15:0] tgt_ff [QUO_W+1];
   rsp_type                 rsp_in, rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[STAGES-2:0], in_valid};
      end
   end

   // compare against max_output times the denominator
   always_ff @(posedge clock) begin
      if (advance) begin
         tgt_ff[0] <= kin.target;
         for (int w = 0; w < WHEELS; w++) begin
            rem_ff[0][w] <= kin.lane[w].num;
            den_ff[0][w] <= kin.lane[w].den;
            quo_ff[0][w] <= '0;
            sat_ff[0][w] <= MXD_W'(kin.lane[w].num) >= kin.lane[w].mxd;
            az_ff[0][w]  <= kin.lane[w].a_zero;
            rz_ff[0][w]  <= kin.lane[w].ar_zero;
         end
      end
   end

   // restoring division, most significant quotient bit first
   for (genvar j = 1; j <= QUO_W; j++) begin : g_step
      localparam int B = QUO_W - j;
      logic [MXD_W-1:0] trial [WHEELS];
      logic [MXD_W-1:0] diff  [WHEELS];
      logic             ge    [WHEELS];

      always_comb begin
         for (int w = 0; w < WHEELS; w++) begin
            trial[w] = MXD_W'(den_ff[j-1][w]) << B;
            ge[w]    = MXD_W'(rem_ff[j-1][w]) >= trial[w];
            diff[w]  = MXD_W'(rem_ff[j-1][w]) - trial[w];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            tgt_ff[j] <= tgt_ff[j-1];
            sat_ff[j] <= sat_ff[j-1];
            az_ff[j]  <= az_ff[j-1];
            rz_ff[j]  <= rz_ff[j-1];
            for (int w = 0; w < WHEELS; w++) begin
               quo_ff[j][w] <= quo_ff[j-1][w] | (QUO_W'(ge[w]) << B);
            end
         end
      end

      if (j < QUO_W) begin : g_keep
         always_ff @(posedge clock) begin
            if (advance) begin
               for (int w = 0; w < WHEELS; w++) begin
                  rem_ff[j][w] <= ge[w] ? diff[w][NUM_W-1:0] : rem_ff[j-1][w];
                  den_ff[j][w] <= den_ff[j-1][w];
               end
            end
         end
      end
   end

   // special cases: no share, wheel standing still, saturation
   always_comb begin
      rsp_in.target = tgt_ff[QUO_W];
      for (int w = 0; w < WHEELS; w++) begin
         if (az_ff[QUO_W][w]) begin
            rsp_in.limit[w] = '0;
         end else if (rz_ff[QUO_W][w] || sat_ff[QUO_W][w]
                      || (quo_ff[QUO_W][w] > max_out)) begin
            rsp_in.limit[w] = max_out;
         end else begin
            rsp_in.limit[w] = quo_ff[QUO_W][w];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

// File: rtl/mecanum_speed_and_current_limit_unit.sv
// An accepted transaction reaches rsp through the kinematics, divider and output stages
// (6 kinematics stages, 17 divider stages, one output register).
// Throughput: one transaction per cycle while the skid entry is free; the restoring current divider
// takes one quotient bit per stage, so it never holds the pipeline.
// A one-entry skid buffer behind the output register; req ready drops while it is full.
// Reset (synchronous, active high) empties the pipeline and restores the configuration registers.
`default_nettype none

module mecanum_speed_and_current_limit_unit (
   input  logic                           clock,
   input  logic                           reset,
   mcl_req_if.sink                        req,
   mcl_rsp_if.source                      rsp,
   input  logic                           csr_wr_en,
   input  logic [mcl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mcl_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mcl_pkg::*;

   cfg_type     cfg_ff;
   cmd_type     cmd;
   logic        advance;
   logic        kin_valid, pipe_valid;
   kin_out_type kin_out;
   rsp_type     pipe_rsp;
   logic        push, pop;
   logic        out_v_ff, out_v_in, skid_v_ff, skid_v_in;
   rsp_type     out_ff, out_in, skid_ff, skid_in;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WIDTH:      cfg_ff.width_mm   <= csr_wdata[11:0];
            CSR_LENGTH:     cfg_ff.length_mm  <= csr_wdata[11:0];
            CSR_INV_RADIUS: cfg_ff.inv_radius <= csr_wdata;
            CSR_POWER:      cfg_ff.power      <= csr_wdata[13:0];
            CSR_MAX_OUT:    cfg_ff.max_out    <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // pipeline moves whenever the skid entry is free
   assign advance   = !skid_v_ff;
   assign req.ready = advance;

   assign cmd.vel_x    = req.vel_x;
   assign cmd.vel_y    = req.vel_y;
   assign cmd.yaw_rate = req.yaw_rate;
   assign cmd.rpm      = {req.rpm_3, req.rpm_2, req.rpm_1, req.rpm_0};

   mcl_kin u_kin (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req.valid),
      .cmd       (cmd),
      .cfg       (cfg_ff),
      .out_valid (kin_valid),
      .kout      (kin_out)
   );

   mcl_cur_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (kin_valid),
      .kin       (kin_out),
      .max_out   (cfg_ff.max_out),
      .out_valid (pipe_valid),
      .rsp       (pipe_rsp)
   );

   // output register with one skid entry
   assign push = advance && pipe_valid;
   assign pop  = out_v_ff && rsp.ready;

   always_comb begin
      out_v_in  = out_v_ff;
      out_in    = out_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (skid_v_ff) begin
         if (pop) begin
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end
      end else if (push) begin
         if (!out_v_ff || pop) begin
            out_in   = pipe_rsp;
            out_v_in = 1'b1;
         end else begin
            skid_in   = pipe_rsp;
            skid_v_in = 1'b1;
         end
      end else if (pop) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp.valid    = out_v_ff;
   assign rsp.target_0 = out_ff.target[0];
   assign rsp.target_1 = out_ff.target[1];
   assign rsp.target_2 = out_ff.target[2];
   assign rsp.target_3 = out_ff.target[3];
   assign rsp.limit_0  = out_ff.limit[0];
   assign rsp.limit_1  = out_ff.limit[1];
   assign rsp.limit_2  = out_ff.limit[2];
   assign rsp.limit_3  = out_ff.limit[3];

endmodule

`default_nettype wire
